// File: design/cop_pkg.sv
// Package for the cylinder overlap push-out block.
// Holds the default widths; no dependencies.
package cop_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int WEIGHT_W        = 16;
endpackage

// File: design/cop_if.sv
// Valid/ready channel interface used by both sides of the block.
// Depends on nothing; the payload type is a parameter.
interface cop_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/cop_sqrt.sv
// Pipelined integer square root and pipelined rounded divider, one result bit per stage.
// Uses cop_pkg; a stall freezes every stage at once.
module cop_sqrt
    import cop_pkg::*;
#(
    parameter int IN_W  = 130,
    parameter int OUT_W = 65
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IN_W-1:0]  i_val,
    output logic [OUT_W-1:0] o_root
);
    logic [IN_W-1:0]  r_num  [OUT_W+1];
    logic [OUT_W-1:0] r_root [OUT_W+1];

    assign r_num[0]  = i_val;
    assign r_root[0] = '0;

    for (genvar s = 0; s < OUT_W; s++) begin : g_st
        logic [OUT_W-1:0] c;
        logic [2*OUT_W-1:0] sq;
        logic [IN_W-1:0]  n_num;
        logic [OUT_W-1:0] n_root;
        logic [IN_W-1:0]  q_num;
        logic [OUT_W-1:0] q_root;
        always_comb begin
            c      = r_root[s] | (OUT_W'(1) << (OUT_W-1-s));
            sq     = c * c;
            n_num  = r_num[s];
            n_root = (2*OUT_W'(0) + sq <= (2*OUT_W)'(r_num[s])) ? c : r_root[s];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                q_num  <= n_num;
                q_root <= n_root;
            end
        end
        assign r_num[s+1]  = q_num;
        assign r_root[s+1] = q_root;
    end

    assign o_root = r_root[OUT_W];
endmodule

// Quotient rounded to nearest, ties upward, of two magnitudes. The quotient
// must fit Q_W bits, so the numerator bits above Q_W already form a partial
// remainder below the divisor. Q_W compare-and-subtract stages and one
// rounding stage form the pipeline.
module cop_rdiv #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 34,
    parameter int Q_W   = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);
    logic [DEN_W-1:0] w_rem [Q_W+1];
    logic [Q_W-1:0]   w_sh  [Q_W+1];
    logic [DEN_W-1:0] w_den [Q_W+1];
    logic [Q_W-1:0]   r_quo;

    assign w_rem[0] = DEN_W'(i_num[NUM_W-1:Q_W]);
    assign w_sh[0]  = i_num[Q_W-1:0];
    assign w_den[0] = i_den;

    // The shift word loses a numerator bit at the top and gains a quotient
    // bit at the bottom in every stage.
    for (genvar s = 0; s < Q_W; s++) begin : g_st
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [Q_W-1:0]   n_sh;
        logic [DEN_W-1:0] r_rem;
        logic [Q_W-1:0]   r_sh;
        logic [DEN_W-1:0] r_den;
        always_comb begin
            trial = {w_rem[s], w_sh[s][Q_W-1]};
            ge    = trial >= {1'b0, w_den[s]};
            n_rem = ge ? DEN_W'(trial - {1'b0, w_den[s]}) : DEN_W'(trial);
            n_sh  = {w_sh[s][Q_W-2:0], ge};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_sh  <= n_sh;
                r_den <= w_den[s];
            end
        end
        assign w_rem[s+1] = r_rem;
        assign w_sh[s+1]  = r_sh;
        assign w_den[s+1] = r_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_quo <= w_sh[Q_W] + Q_W'({w_rem[Q_W], 1'b0} >= {1'b0, w_den[Q_W]});
    end

    assign o_quo = r_quo;
endmodule

// File: design/cylinder_overlap_pushout.sv
// Top level of the cylinder overlap push-out block.
// Uses cop_pkg, cop_sqrt and cop_rdiv.
//
// channel  | dir | payload
// in_ch    | in  | a_x..a_height, b_x..b_height
// out_ch   | out | hit, new_a_x, new_a_z, new_b_x, new_b_z
//
// One item enters per cycle while the output is not stalled. Its result passes through
// two stages of differences and squares, COORD_WIDTH+2 square-root stages,
// two stages for depth and products, two dividers of COORD_WIDTH+1 stages
// with a product stage between them, and two final stages. Reset clears the valid
// bits only. A stall at the output freezes the whole pipeline and drops o_ready,
// so no item is lost or repeated.
module cylinder_overlap_pushout
    import cop_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [COORD_WIDTH-1:0] i_a_x, i_a_y, i_a_z,
    input  logic [COORD_WIDTH-2:0] i_a_radius, i_a_height,
    input  logic [WEIGHT_W-1:0]    i_a_weight,
    input  logic [COORD_WIDTH-1:0] i_b_x, i_b_y, i_b_z,
    input  logic [COORD_WIDTH-2:0] i_b_radius, i_b_height,
    input  logic [WEIGHT_W-1:0]    i_b_weight,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output logic o_hit,
    output logic [COORD_WIDTH-1:0] o_new_a_x, o_new_a_z, o_new_b_x, o_new_b_z
);
    localparam int C = COORD_WIDTH;
    localparam int SQ_IN = 2*C+4;
    localparam int SQ_OUT = C+2;
    localparam int FB = FRAC_BITS; // same format everywhere, integer math
    localparam int DIV_LAT = C+1;

    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // Stage 1: differences and overlap tests.
    logic r1_v, r1_vert;
    logic signed [C:0] r1_dx, r1_dy, r1_dz;
    logic [C-1:0] r1_rng;
    logic signed [C-1:0] r1_ax, r1_az, r1_bx, r1_bz;
    logic [WEIGHT_W-1:0] r1_wa, r1_wb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
        if (en) begin
            r1_vert <= !($signed(i_a_y) > $signed({i_b_y[C-1], i_b_y}) + $signed({2'b0, i_b_height}))
                    && !($signed({i_a_y[C-1], i_a_y}) + $signed({2'b0, i_a_height}) < $signed(i_b_y));
            r1_dx <= $signed({i_b_x[C-1], i_b_x}) - $signed({i_a_x[C-1], i_a_x});
            r1_dy <= $signed({i_b_y[C-1], i_b_y}) - $signed({i_a_y[C-1], i_a_y});
            r1_dz <= $signed({i_b_z[C-1], i_b_z}) - $signed({i_a_z[C-1], i_a_z});
            r1_rng <= {1'b0, i_a_radius} + {1'b0, i_b_radius};
            r1_ax <= i_a_x; r1_az <= i_a_z; r1_bx <= i_b_x; r1_bz <= i_b_z;
            r1_wa <= i_a_weight; r1_wb <= i_b_weight;
        end
    end

    // Stage 2: squares. Each magnitude fits C bits.
    logic r2_v, r2_vert, r2_sx, r2_sz;
    logic [C-1:0] r2_mx, r2_mz;
    logic [SQ_IN-1:0] r2_h2, r2_d2, r2_r2;
    logic [C-1:0] r2_rng;
    logic signed [C-1:0] r2_ax, r2_az, r2_bx, r2_bz;
    logic [WEIGHT_W-1:0] r2_wa, r2_wb;
    logic [C:0] mx, my, mz;
    logic [2*C+1:0] sq_x, sq_y, sq_z;
    logic [2*C-1:0] sq_r;
    assign mx = r1_dx[C] ? (C+1)'(-r1_dx) : r1_dx;
    assign my = r1_dy[C] ? (C+1)'(-r1_dy) : r1_dy;
    assign mz = r1_dz[C] ? (C+1)'(-r1_dz) : r1_dz;
    assign sq_x = mx * mx;
    assign sq_y = my * my;
    assign sq_z = mz * mz;
    assign sq_r = r1_rng * r1_rng;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_vert <= r1_vert;
            r2_sx <= r1_dx[C]; r2_sz <= r1_dz[C];
            r2_mx <= mx[C-1:0]; r2_mz <= mz[C-1:0];
            r2_h2 <= SQ_IN'(sq_x) + SQ_IN'(sq_z);
            r2_d2 <= SQ_IN'(sq_x) + SQ_IN'(sq_z) + SQ_IN'(sq_y);
            r2_r2 <= SQ_IN'(sq_r);
            r2_rng <= r1_rng;
            r2_ax <= r1_ax; r2_az <= r1_az; r2_bx <= r1_bx; r2_bz <= r1_bz;
            r2_wa <= r1_wa; r2_wb <= r1_wb;
        end
    end

    // Square roots, pipelined; side data delayed alongside.
    logic [SQ_OUT-1:0] d_root, h_root;
    cop_sqrt #(.IN_W(SQ_IN), .OUT_W(SQ_OUT)) u_sqd (
        .i_clk(i_clk), .i_en(en), .i_val(r2_d2), .o_root(d_root));
    cop_sqrt #(.IN_W(SQ_IN), .OUT_W(SQ_OUT)) u_sqh (
        .i_clk(i_clk), .i_en(en), .i_val(r2_h2), .o_root(h_root));

    localparam int SW = 1 + 1 + 1 + 1 + 2*C + C + 4*C + 2*WEIGHT_W + 1;
    logic [SW-1:0] dl [SQ_OUT+1];
    assign dl[0] = {r2_v, r2_vert && (r2_d2 <= r2_r2), r2_sx, r2_sz, r2_mx, r2_mz,
                    r2_rng, r2_ax, r2_az, r2_bx, r2_bz, r2_wa, r2_wb, r2_h2 != '0};
    for (genvar k = 0; k < SQ_OUT; k++) begin : g_dl
        logic [SW-1:0] q;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) q[SW-1] <= 1'b0;
            else if (en) q[SW-1] <= dl[k][SW-1];
            if (en) q[SW-2:0] <= dl[k][SW-2:0];
        end
        assign dl[k+1] = q;
    end

    logic s_v, s_hit, s_sx, s_sz, s_nz;
    logic [C-1:0] s_mx, s_mz;
    logic [C-1:0] s_rng;
    logic signed [C-1:0] s_ax, s_az, s_bx, s_bz;
    logic [WEIGHT_W-1:0] s_wa, s_wb;
    assign {s_v, s_hit, s_sx, s_sz, s_mx, s_mz, s_rng, s_ax, s_az, s_bx, s_bz,
            s_wa, s_wb, s_nz} = dl[SQ_OUT];

    // Stage 3: penetration depth and XZ length. The length is only a divisor
    // when the XZ difference is nonzero, so a zero root is replaced by one.
    logic r3_v, r3_hit, r3_sx, r3_sz, r3_nz;
    logic [C-1:0] r3_depth, r3_mx, r3_mz;
    logic [SQ_OUT-1:0] r3_hl;
    logic signed [C-1:0] r3_ax, r3_az, r3_bx, r3_bz;
    logic [WEIGHT_W-1:0] r3_wa, r3_wb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= s_v;
        if (en) begin
            r3_hit <= s_hit; r3_sx <= s_sx; r3_sz <= s_sz; r3_nz <= s_nz;
            r3_depth <= C'(SQ_OUT'(s_rng) - d_root);
            r3_hl <= (h_root == '0) ? SQ_OUT'(1) : h_root;
            r3_mx <= s_mx; r3_mz <= s_mz;
            r3_ax <= s_ax; r3_az <= s_az; r3_bx <= s_bx; r3_bz <= s_bz;
            r3_wa <= s_wa; r3_wb <= s_wb;
        end
    end

    // Stage 4: push numerators, and the weight share with a zero weight sum
    // turned into an even split.
    logic [2*C-1:0] num_x, num_z;
    assign num_x = r3_depth * r3_mx;
    assign num_z = r3_depth * r3_mz;
    logic r4_v, r4_hit, r4_sx, r4_sz, r4_nz;
    logic [2*C-1:0] r4_numx, r4_numz;
    logic [SQ_OUT-1:0] r4_hl;
    logic signed [C-1:0] r4_ax, r4_az, r4_bx, r4_bz;
    logic [WEIGHT_W-1:0] r4_wa;
    logic [WEIGHT_W:0] r4_ws;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
        if (en) begin
            r4_hit <= r3_hit; r4_sx <= r3_sx; r4_sz <= r3_sz; r4_nz <= r3_nz;
            r4_numx <= num_x; r4_numz <= num_z; r4_hl <= r3_hl;
            r4_ax <= r3_ax; r4_az <= r3_az; r4_bx <= r3_bx; r4_bz <= r3_bz;
            if (r3_wa == '0 && r3_wb == '0) begin
                r4_wa <= WEIGHT_W'(1);
                r4_ws <= (WEIGHT_W+1)'(2);
            end else begin
                r4_wa <= r3_wa;
                r4_ws <= {1'b0, r3_wa} + {1'b0, r3_wb};
            end
        end
    end

    // Push per axis: depth * |d| / L, at most the depth, so C bits hold it.
    logic [C-1:0] px, pz;
    cop_rdiv #(.NUM_W(2*C), .DEN_W(SQ_OUT), .Q_W(C)) u_divx (
        .i_clk(i_clk), .i_en(en), .i_num(r4_numx), .i_den(r4_hl), .o_quo(px));
    cop_rdiv #(.NUM_W(2*C), .DEN_W(SQ_OUT), .Q_W(C)) u_divz (
        .i_clk(i_clk), .i_en(en), .i_num(r4_numz), .i_den(r4_hl), .o_quo(pz));

    localparam int D1W = 4 + 4*C + 1 + 2*WEIGHT_W + 1;
    logic [D1W-1:0] dl1 [DIV_LAT+1];
    assign dl1[0] = {r4_v, r4_hit, r4_sx, r4_sz, r4_ax, r4_az, r4_bx, r4_bz, r4_nz,
                     r4_wa, r4_ws};
    for (genvar k = 0; k < DIV_LAT; k++) begin : g_dl1
        logic [D1W-1:0] q;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) q[D1W-1] <= 1'b0;
            else if (en) q[D1W-1] <= dl1[k][D1W-1];
            if (en) q[D1W-2:0] <= dl1[k][D1W-2:0];
        end
        assign dl1[k+1] = q;
    end

    logic d1_v, d1_hit, d1_sx, d1_sz, d1_nz;
    logic signed [C-1:0] d1_ax, d1_az, d1_bx, d1_bz;
    logic [WEIGHT_W-1:0] d1_wa;
    logic [WEIGHT_W:0] d1_ws;
    assign {d1_v, d1_hit, d1_sx, d1_sz, d1_ax, d1_az, d1_bx, d1_bz, d1_nz,
            d1_wa, d1_ws} = dl1[DIV_LAT];

    // Stage 5: numerators of B's share.
    logic [C+WEIGHT_W-1:0] num_bx, num_bz;
    assign num_bx = px * d1_wa;
    assign num_bz = pz * d1_wa;
    logic r5_v, r5_hit, r5_sx, r5_sz, r5_nz;
    logic signed [C-1:0] r5_ax, r5_az, r5_bx, r5_bz;
    logic [C-1:0] r5_px, r5_pz;
    logic [C+WEIGHT_W-1:0] r5_numx, r5_numz;
    logic [WEIGHT_W:0] r5_ws;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= d1_v;
        if (en) begin
            r5_hit <= d1_hit; r5_sx <= d1_sx; r5_sz <= d1_sz; r5_nz <= d1_nz;
            r5_ax <= d1_ax; r5_az <= d1_az; r5_bx <= d1_bx; r5_bz <= d1_bz;
            r5_px <= px; r5_pz <= pz;
            r5_numx <= num_bx; r5_numz <= num_bz; r5_ws <= d1_ws;
        end
    end

    logic [C-1:0] bsx, bsz;
    cop_rdiv #(.NUM_W(C+WEIGHT_W), .DEN_W(WEIGHT_W+1), .Q_W(C)) u_divbx (
        .i_clk(i_clk), .i_en(en), .i_num(r5_numx), .i_den(r5_ws), .o_quo(bsx));
    cop_rdiv #(.NUM_W(C+WEIGHT_W), .DEN_W(WEIGHT_W+1), .Q_W(C)) u_divbz (
        .i_clk(i_clk), .i_en(en), .i_num(r5_numz), .i_den(r5_ws), .o_quo(bsz));

    localparam int D2W = 4 + 4*C + 1 + 2*C;
    logic [D2W-1:0] dl2 [DIV_LAT+1];
    assign dl2[0] = {r5_v, r5_hit, r5_sx, r5_sz, r5_ax, r5_az, r5_bx, r5_bz, r5_nz,
                     r5_px, r5_pz};
    for (genvar k = 0; k < DIV_LAT; k++) begin : g_dl2
        logic [D2W-1:0] q;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) q[D2W-1] <= 1'b0;
            else if (en) q[D2W-1] <= dl2[k][D2W-1];
            if (en) q[D2W-2:0] <= dl2[k][D2W-2:0];
        end
        assign dl2[k+1] = q;
    end

    logic d2_v, d2_hit, d2_sx, d2_sz, d2_nz;
    logic signed [C-1:0] d2_ax, d2_az, d2_bx, d2_bz;
    logic [C-1:0] d2_px, d2_pz;
    assign {d2_v, d2_hit, d2_sx, d2_sz, d2_ax, d2_az, d2_bx, d2_bz, d2_nz,
            d2_px, d2_pz} = dl2[DIV_LAT];

    // Stage 6: A takes whatever part of the push B does not.
    logic r6_v, r6_hit, r6_push, r6_sx, r6_sz;
    logic signed [C-1:0] r6_ax, r6_az, r6_bx, r6_bz;
    logic [C-1:0] r6_bsx, r6_bsz, r6_asx, r6_asz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= d2_v;
        if (en) begin
            r6_hit <= d2_hit; r6_push <= d2_hit && d2_nz;
            r6_sx <= d2_sx; r6_sz <= d2_sz;
            r6_ax <= d2_ax; r6_az <= d2_az; r6_bx <= d2_bx; r6_bz <= d2_bz;
            r6_bsx <= bsx; r6_bsz <= bsz;
            r6_asx <= d2_px - bsx; r6_asz <= d2_pz - bsz;
        end
    end

    // Final stage: signed moves and saturation to the coordinate range.
    localparam logic signed [C+1:0] SAT_HI = (C+2)'((64'd1 << (C-1)) - 64'd1);
    localparam logic signed [C+1:0] SAT_LO = ~SAT_HI;
    logic signed [C+1:0] nax, naz, nbx, nbz;
    always_comb begin
        nbx = r6_sx ? $signed({{2{r6_bx[C-1]}}, r6_bx}) - $signed({2'b0, r6_bsx})
                    : $signed({{2{r6_bx[C-1]}}, r6_bx}) + $signed({2'b0, r6_bsx});
        nax = r6_sx ? $signed({{2{r6_ax[C-1]}}, r6_ax}) + $signed({2'b0, r6_asx})
                    : $signed({{2{r6_ax[C-1]}}, r6_ax}) - $signed({2'b0, r6_asx});
        nbz = r6_sz ? $signed({{2{r6_bz[C-1]}}, r6_bz}) - $signed({2'b0, r6_bsz})
                    : $signed({{2{r6_bz[C-1]}}, r6_bz}) + $signed({2'b0, r6_bsz});
        naz = r6_sz ? $signed({{2{r6_az[C-1]}}, r6_az}) + $signed({2'b0, r6_asz})
                    : $signed({{2{r6_az[C-1]}}, r6_az}) - $signed({2'b0, r6_asz});
    end

    function automatic logic [C-1:0] f_sat(logic signed [C+1:0] v);
        return (v > SAT_HI) ? SAT_HI[C-1:0] : (v < SAT_LO) ? SAT_LO[C-1:0] : v[C-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= r6_v;
        if (en) begin
            o_hit <= r6_hit;
            if (r6_push) begin
                o_new_a_x <= f_sat(nax); o_new_a_z <= f_sat(naz);
                o_new_b_x <= f_sat(nbx); o_new_b_z <= f_sat(nbz);
            end else begin
                o_new_a_x <= r6_ax; o_new_a_z <= r6_az;
                o_new_b_x <= r6_bx; o_new_b_z <= r6_bz;
            end
        end
    end
endmodule

// File: design/cop_checker.sv
// Port-level checker for the push-out block, bound to the top level.
// Depends on cylinder_overlap_pushout.
module cop_checker (
    input logic i_clk, i_rst_n, i_ready, o_valid, o_ready, o_hit
);
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("output dropped");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("not ready while empty");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_hit)) else $error("hit changed");
endmodule

bind cylinder_overlap_pushout cop_checker u_chk (.*);

// File: sim/tb_cylinder_overlap_pushout.sv
// Testbench for cylinder_overlap_pushout: directed and random body pairs.
// Depends on cop_pkg, cop_if and the block itself; needs no other files.
module tb_cylinder_overlap_pushout;
    import cop_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;

    typedef struct packed {
        logic [CW-1:0]       a_x, a_y, a_z;
        logic [CW-2:0]       a_radius;
        logic [WEIGHT_W-1:0] a_weight;
        logic [CW-2:0]       a_height;
        logic [CW-1:0]       b_x, b_y, b_z;
        logic [CW-2:0]       b_radius;
        logic [WEIGHT_W-1:0] b_weight;
        logic [CW-2:0]       b_height;
    } body_pair_t;

    typedef struct packed {
        logic          hit;
        logic [CW-1:0] new_a_x, new_a_z, new_b_x, new_b_z;
    } pushout_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cop_if #(.T(body_pair_t)) pair_ch (i_clk);
    cop_if #(.T(pushout_t))   push_ch (i_clk);

    always #5 i_clk = ~i_clk;

    cylinder_overlap_pushout DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_a_x      (pair_ch.data.a_x),
        .i_a_y      (pair_ch.data.a_y),
        .i_a_z      (pair_ch.data.a_z),
        .i_a_radius (pair_ch.data.a_radius),
        .i_a_height (pair_ch.data.a_height),
        .i_a_weight (pair_ch.data.a_weight),
        .i_b_x      (pair_ch.data.b_x),
        .i_b_y      (pair_ch.data.b_y),
        .i_b_z      (pair_ch.data.b_z),
        .i_b_radius (pair_ch.data.b_radius),
        .i_b_height (pair_ch.data.b_height),
        .i_b_weight (pair_ch.data.b_weight),
        .i_valid    (pair_ch.valid),
        .o_ready    (pair_ch.ready),
        .o_valid    (push_ch.valid),
        .i_ready    (push_ch.ready),
        .o_hit      (push_ch.data.hit),
        .o_new_a_x  (push_ch.data.new_a_x),
        .o_new_a_z  (push_ch.data.new_a_z),
        .o_new_b_x  (push_ch.data.new_b_x),
        .o_new_b_z  (push_ch.data.new_b_z)
    );

    pushout_t expected_pushouts[$];
    int       error_count = 0;
    int       pairs_sent = 0;
    int       hits_seen = 0;
    int       pushouts_checked = 0;

    // Floor square root of a value up to 128 bits, built one bit at a time.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  root;
        logic [63:0]  trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= n) root = trial;
        end
        return root;
    endfunction

    // num / den rounded to nearest, ties upward (all operands are magnitudes).
    function automatic logic [63:0] round_div(input logic [127:0] num,
                                              input logic [63:0] den);
        logic [129:0] wide;
        wide = ({2'b0, num} * 130'd2 + 130'(den)) / (130'(den) * 130'd2);
        return wide[63:0];
    endfunction

    function automatic longint saturate(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Predicts the push-out of one pair of upright cylinders.
    function automatic pushout_t predict_pushout(input body_pair_t p);
        pushout_t     r;
        longint       ax, ay, az, bx, by, bz, dx, dy, dz;
        longint       ah, bh, nax, naz, nbx, nbz;
        logic [63:0]  mx, my, mz, reach, depth, xz_len, px, pz;
        logic [63:0]  wa, wb, ws, bsx, bsz, asx, asz;
        logic [127:0] xz_sq, dist_sq;
        ax = longint'($signed(p.a_x)); ay = longint'($signed(p.a_y));
        az = longint'($signed(p.a_z));
        bx = longint'($signed(p.b_x)); by = longint'($signed(p.b_y));
        bz = longint'($signed(p.b_z));
        ah = longint'(p.a_height); bh = longint'(p.b_height);
        nax = ax; naz = az; nbx = bx; nbz = bz;
        r.hit = 1'b0;
        if (!(ay > by + bh) && !(ay + ah < by)) begin
            dx = bx - ax; dy = by - ay; dz = bz - az;
            mx = (dx < 0) ? -dx : dx;
            my = (dy < 0) ? -dy : dy;
            mz = (dz < 0) ? -dz : dz;
            reach = 64'(p.a_radius) + 64'(p.b_radius);
            xz_sq = 128'(mx) * 128'(mx) + 128'(mz) * 128'(mz);
            dist_sq = xz_sq + 128'(my) * 128'(my);
            if (dist_sq <= 128'(reach) * 128'(reach)) begin
                r.hit = 1'b1;
                // Coincident XZ positions leave both bodies where they are.
                if (xz_sq != 0) begin
                    depth = reach - floor_sqrt(dist_sq);
                    xz_len = floor_sqrt(xz_sq);
                    px = round_div(128'(depth) * 128'(mx), xz_len);
                    pz = round_div(128'(depth) * 128'(mz), xz_len);
                    wa = 64'(p.a_weight); wb = 64'(p.b_weight);
                    if (wa + wb == 0) begin
                        wa = 1; wb = 1;
                    end
                    ws = wa + wb;
                    bsx = round_div(128'(px) * 128'(wa), ws);
                    bsz = round_div(128'(pz) * 128'(wa), ws);
                    asx = px - bsx;
                    asz = pz - bsz;
                    if (dx < 0) begin
                        nbx = bx - longint'(bsx); nax = ax + longint'(asx);
                    end else begin
                        nbx = bx + longint'(bsx); nax = ax - longint'(asx);
                    end
                    if (dz < 0) begin
                        nbz = bz - longint'(bsz); naz = az + longint'(asz);
                    end else begin
                        nbz = bz + longint'(bsz); naz = az - longint'(asz);
                    end
                    nax = saturate(nax); naz = saturate(naz);
                    nbx = saturate(nbx); nbz = saturate(nbz);
                end
            end
        end
        r.new_a_x = nax[CW-1:0]; r.new_a_z = naz[CW-1:0];
        r.new_b_x = nbx[CW-1:0]; r.new_b_z = nbz[CW-1:0];
        return r;
    endfunction

    // Sends one pair; valid stays high across back-to-back items and only
    // drops when the next item draws a gap.
    task automatic send_pair(input body_pair_t p);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            pair_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pair_ch.data = p;
        pair_ch.valid = 1'b1;
        do @(posedge i_clk); while (!pair_ch.ready);
        expected_pushouts.push_back(predict_pushout(p));
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Output side: random stalls, and every accepted result checked in order.
    initial begin
        int stall;
        push_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            push_ch.ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            push_ch.ready = 1'b1;
            do @(posedge i_clk); while (!push_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        pushout_t exp_r;
        if (i_rst_n && push_ch.valid && push_ch.ready) begin
            if (expected_pushouts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, push_ch.data);
                error_count++;
            end else begin
                exp_r = expected_pushouts.pop_front();
                pushouts_checked++;
                if (push_ch.data.hit) hits_seen++;
                if (push_ch.data.hit !== exp_r.hit) begin
                    $display("%0t: hit expected %b actual %b", $time,
                             exp_r.hit, push_ch.data.hit);
                    error_count++;
                end
                if (push_ch.data.new_a_x !== exp_r.new_a_x) begin
                    $display("%0t: new_a_x expected %h actual %h", $time,
                             exp_r.new_a_x, push_ch.data.new_a_x);
                    error_count++;
                end
                if (push_ch.data.new_a_z !== exp_r.new_a_z) begin
                    $display("%0t: new_a_z expected %h actual %h", $time,
                             exp_r.new_a_z, push_ch.data.new_a_z);
                    error_count++;
                end
                if (push_ch.data.new_b_x !== exp_r.new_b_x) begin
                    $display("%0t: new_b_x expected %h actual %h", $time,
                             exp_r.new_b_x, push_ch.data.new_b_x);
                    error_count++;
                end
                if (push_ch.data.new_b_z !== exp_r.new_b_z) begin
                    $display("%0t: new_b_z expected %h actual %h", $time,
                             exp_r.new_b_z, push_ch.data.new_b_z);
                    error_count++;
                end
            end
        end
    end

    function automatic body_pair_t make_pair(
        input longint ax, ay, az, ar, aw, ah, bx, by, bz, br, bw, bh);
        body_pair_t p;
        p.a_x = ax[CW-1:0]; p.a_y = ay[CW-1:0]; p.a_z = az[CW-1:0];
        p.a_radius = ar[CW-2:0]; p.a_weight = aw[WEIGHT_W-1:0];
        p.a_height = ah[CW-2:0];
        p.b_x = bx[CW-1:0]; p.b_y = by[CW-1:0]; p.b_z = bz[CW-1:0];
        p.b_radius = br[CW-2:0]; p.b_weight = bw[WEIGHT_W-1:0];
        p.b_height = bh[CW-2:0];
        return p;
    endfunction

    // Hand-picked cases: every branch of the resolution and the field limits.
    task automatic test_directed_cases();
        longint one, cmax, cmin, lmax;
        one = 64'h10000;
        lmax = (longint'(1) <<< (CW - 1)) - 1;
        cmax = lmax; cmin = -lmax - 1;
        // Vertical spans apart, in both orders.
        send_pair(make_pair(0, 0, 0, one, 1, one, one / 2, 3 * one, 0, one, 1, one));
        send_pair(make_pair(0, 3 * one, 0, one, 1, one, one / 2, 0, 0, one, 1, one));
        // Spans just touching at the top.
        send_pair(make_pair(0, 0, 0, one, 1, one, one, one, 0, one, 1, one));
        // Too far apart in the plane.
        send_pair(make_pair(0, 0, 0, one, 5, 9 * one, 3 * one, 0, 0, one, 5, 9 * one));
        // Exactly touching and overlapping along each axis and diagonally.
        send_pair(make_pair(0, 0, 0, one, 3, one, 2 * one, 0, 0, one, 1, one));
        send_pair(make_pair(0, 0, 0, one, 3, one, one, 0, 0, one, 1, one));
        send_pair(make_pair(0, 0, 0, one, 3, one, 0, 0, -one, one, 1, one));
        send_pair(make_pair(one, 0, one, one, 2, one, 0, 0, 0, one, 7, one));
        // Coincident XZ positions: hit with no push.
        send_pair(make_pair(5 * one, 0, -one, one, 1, one, 5 * one, one / 2, -one,
                            one, 1, one));
        // Zero weight sum, and one-sided weights.
        send_pair(make_pair(0, 0, 0, one, 0, one, one, 0, one, one, 0, one));
        send_pair(make_pair(0, 0, 0, one, 65535, one, one, 0, one, one, 0, one));
        send_pair(make_pair(0, 0, 0, one, 0, one, one, 0, one, one, 65535, one));
        // Vertical offset eats into the 3D distance.
        send_pair(make_pair(0, 0, 0, 2 * one, 1, lmax, one, one, 0, one, 1, lmax));
        // Pushes that saturate at both ends of the range.
        send_pair(make_pair(cmin + 4, 0, cmin + 4, lmax, 1, lmax, cmin + 5, 0,
                            cmin + 5, lmax, 65535, lmax));
        send_pair(make_pair(cmax - 4, 0, cmax - 4, lmax, 65535, lmax, cmax - 5, 0,
                            cmax - 5, lmax, 1, lmax));
        send_pair(make_pair(cmax, cmin, cmax, lmax, 65535, lmax, cmin, cmax, cmin,
                            lmax, 65535, lmax));
        // All-zero and all-ones field patterns.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(-1, -1, -1, lmax, 65535, lmax, -1, -1, -1, lmax, 65535,
                            lmax));
        send_pair(make_pair(cmin, cmin, cmin, 0, 0, 0, cmax, cmax, cmax, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, lmax, 65535, lmax, 1, 0, 0, lmax, 65535, lmax));
    endtask

    // Pairs placed near each other so most of them collide; sizes vary from
    // tiny to huge to reach rounding and saturation.
    task automatic test_random_contacts(input int count);
        body_pair_t p;
        longint     ax, ay, az, span, rmax;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: span = 64'h100;
                1: span = 64'h40000;
                2: span = 64'h4000000;
                default: span = 64'h7FFFFFFF;
            endcase
            rmax = span;
            ax = longint'($signed($urandom)); ay = longint'($signed($urandom));
            az = longint'($signed($urandom));
            p = make_pair(ax, ay, az,
                          longint'($urandom_range(0, int'(rmax))),
                          longint'($urandom_range(0, 65535)),
                          $urandom_range(0, 1) ? longint'($urandom) & 64'h7FFFFFFF
                                               : longint'($urandom_range(0, int'(rmax))),
                          ax + longint'($urandom_range(0, int'(span))) - span / 2,
                          ay + longint'($urandom_range(0, int'(span))) - span / 2,
                          az + longint'($urandom_range(0, int'(span))) - span / 2,
                          longint'($urandom_range(0, int'(rmax))),
                          ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 65535)),
                          $urandom_range(0, 1) ? longint'($urandom) & 64'h7FFFFFFF
                                               : longint'($urandom_range(0, int'(rmax))));
            if ($urandom_range(0, 7) == 0) p.a_weight = '0;
            send_pair(p);
        end
    endtask

    // Fully random fields, mostly misses, so every bit toggles.
    task automatic test_random_noise(input int count);
        body_pair_t p;
        for (int i = 0; i < count; i++) begin
            p = make_pair(longint'($urandom), longint'($urandom), longint'($urandom),
                          longint'($urandom), longint'($urandom), longint'($urandom),
                          longint'($urandom), longint'($urandom), longint'($urandom),
                          longint'($urandom), longint'($urandom), longint'($urandom));
            send_pair(p);
        end
    endtask

    initial begin
        int drain;
        pair_ch.valid = 1'b0;
        pair_ch.data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_contacts(950);
        test_random_noise(180);
        pair_ch.valid = 1'b0;

        drain = 0;
        while (expected_pushouts.size() != 0 && drain < 100000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (50) @(negedge i_clk);

        $display("Sent %0d body pairs; checked %0d results, %0d of them hits.",
                 pairs_sent, pushouts_checked, hits_seen);
        if (error_count == 0 && expected_pushouts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing.", error_count,
                     expected_pushouts.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", expected_pushouts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
